### rtl/tlms_pkg.sv
// Shared types, constants and duration tables of the twinkle lamp mode sequencer.
// Used by tlms_chan, the top level, tlms_checker and testbench; depends on nothing else.
package tlms_pkg;

  // sizing
  localparam int CHANNELS  = 4;
  localparam int STEPS     = 8;
  localparam int PATTERNS  = 3;
  localparam int LAMPS_OUT = 4;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int STEP_W    = $clog2(STEPS);
  localparam int ELAPSED_W = 10;
  localparam int TAB_W     = 3;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // channel mode codes
  localparam logic [7:0] MODE_OFF   = 8'd0;
  localparam logic [7:0] MODE_ON    = 8'd1;
  localparam logic [7:0] MODE_PAT_A = 8'd2;
  localparam logic [7:0] MODE_PAT_C = 8'd4;

  // request kinds
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SLOT = 1'b1;

  // register offsets
  localparam logic [2:0] REG_CHANNEL_GROUP = 3'd0;

  // on and off durations in ms, per pattern and step
  localparam logic [ELAPSED_W-1:0] LIT_TIME [PATTERNS][8] = '{
    '{10'd18, 10'd23, 10'd16, 10'd15, 10'd14, 10'd12, 10'd21, 10'd12},
    '{10'd12, 10'd17, 10'd11, 10'd15, 10'd14, 10'd12, 10'd17, 10'd12},
    '{10'd6,  10'd8,  10'd6,  10'd7,  10'd7,  10'd6,  10'd9,  10'd6}
  };
  localparam logic [ELAPSED_W-1:0] DARK_TIME [PATTERNS][8] = '{
    '{10'd65,  10'd75,  10'd45,  10'd33,  10'd65,  10'd22,  10'd45,  10'd67},
    '{10'd250, 10'd450, 10'd175, 10'd345, 10'd476, 10'd225, 10'd345, 10'd198},
    '{10'd500, 10'd900, 10'd350, 10'd690, 10'd925, 10'd500, 10'd690, 10'd400}
  };

  // per-channel request control
  typedef struct packed {
    logic       tick;
    logic       mode_we;
    logic [7:0] mode;
  } tlms_ctrl_t;

endpackage

### rtl/tlms_chan.sv
// One lamp channel: mode register, lamp level and three twinkle pattern timers.
// Depends on tlms_pkg.
module tlms_chan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tlms_pkg::tlms_ctrl_t ctrl_i,
  output logic               lamp_o,
  output logic               lamp_nx_o
);
  import tlms_pkg::*;

  logic [7:0]           mode_q, mode_d;
  logic                 lamp_q, lamp_d;
  logic [PATTERNS-1:0]  lit_q, lit_d;
  logic [STEP_W-1:0]    step_q [PATTERNS];
  logic [STEP_W-1:0]    step_d [PATTERNS];
  logic [ELAPSED_W-1:0] el_q   [PATTERNS];
  logic [ELAPSED_W-1:0] el_d   [PATTERNS];
  logic [ELAPSED_W-1:0] el_inc [PATTERNS];
  logic [TAB_W-1:0]     tab_idx [PATTERNS];
  logic [STEP_W:0]      step_nx [PATTERNS];
  logic [1:0]           pat_sel;
  logic                 pat_mode;

  assign pat_mode = (mode_q >= MODE_PAT_A) && (mode_q <= MODE_PAT_C);
  assign pat_sel  = 2'(mode_q - MODE_PAT_A);

  // timers, compares and lamp update
  always_comb begin
    mode_d = ctrl_i.mode_we ? ctrl_i.mode : mode_q;
    lamp_d = lamp_q;
    lit_d  = lit_q;
    for (int p = 0; p < PATTERNS; p++) begin
      el_inc[p]  = (el_q[p] == ELAPSED_MAX) ? el_q[p] : el_q[p] + 1'b1;
      tab_idx[p] = TAB_W'(step_q[p]);
      step_nx[p] = {1'b0, step_q[p]} + 1'b1;
      step_d[p]  = step_q[p];
      el_d[p]    = ctrl_i.tick ? el_inc[p] : el_q[p];
    end
    if (ctrl_i.tick) begin
      if (mode_q == MODE_OFF) begin
        lamp_d = 1'b0;
      end else if (mode_q == MODE_ON) begin
        lamp_d = 1'b1;
      end else if (pat_mode) begin
        for (int p = 0; p < PATTERNS; p++) begin
          if (pat_sel == 2'(p)) begin
            if (lit_q[p]) begin
              if (el_inc[p] >= LIT_TIME[p][tab_idx[p]]) begin
                lamp_d   = 1'b0;
                lit_d[p] = 1'b0;
                el_d[p]  = '0;
              end
            end else if (el_inc[p] >= DARK_TIME[p][tab_idx[p]]) begin
              lamp_d   = 1'b1;
              lit_d[p] = 1'b1;
              el_d[p]  = '0;
              step_d[p] = (step_nx[p] >= (STEP_W+1)'(STEPS)) ? '0 : step_nx[p][STEP_W-1:0];
            end
          end
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_OFF;
      lamp_q <= 1'b0;
      lit_q  <= '1;
      for (int p = 0; p < PATTERNS; p++) begin
        step_q[p] <= '0;
        el_q[p]   <= '0;
      end
    end else begin
      mode_q <= mode_d;
      lamp_q <= lamp_d;
      lit_q  <= lit_d;
      for (int p = 0; p < PATTERNS; p++) begin
        step_q[p] <= step_d[p];
        el_q[p]   <= el_d[p];
      end
    end
  end

  assign lamp_o    = lamp_q;
  // level the lamp takes at this edge
  assign lamp_nx_o = lamp_d;

endmodule

### rtl/twinkle_lamp_mode_sequencer.sv
// Top level of the twinkle lamp mode sequencer: request decode, channel group
// register, lamp channels and a two-entry result queue. Depends on tlms_pkg, tlms_chan.
//
//  channel   dir  handshake                fields
//  s_axis    in   s_axis_tvalid/tready     tuser: req_type; tdata: slot_index, slot_value
//  m_axis    out  m_axis_tvalid/tready     tdata: lamp_zero .. lamp_three
//  apb       in   psel/penable/pready      channel_group at offset 0
//
// one request per clock while s_axis_tready is high; its result enters the result
// queue at the same edge and is offered on m_axis from the next cycle
// the two-entry result queue lets requests keep flowing while a result waits;
// s_axis_tready drops only when both entries are held
// reset restores all modes, lamps and pattern timers at once, no sweep
module twinkle_lamp_mode_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [8:0] slot_index, [16:9] slot_value, rest zero
  input  logic        s_axis_tuser,   // [0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] lamp_zero, [1] lamp_one, [2] lamp_two,
                                      // [3] lamp_three, rest zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tlms_pkg::*;

  logic [3:0]           group_q;
  logic                 in_acc, out_acc;
  logic [8:0]           slot_index;
  logic [7:0]           slot_value;
  logic [9:0]           slot_base, slot_off;
  logic                 slot_hit;
  logic [CH_W-1:0]      slot_ch;
  tlms_ctrl_t           ctrl [CHANNELS];
  logic [CHANNELS-1:0]  lamp_now, lamp_nx;
  logic [LAMPS_OUT-1:0] res_bits;
  logic [LAMPS_OUT-1:0] fifo_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           cnt_q, cnt_d;

  // configuration port
  assign pready = 1'b1;
  assign prdata = {28'd0, group_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CHANNEL_GROUP[2])) begin
      group_q <= pwdata[3:0];
    end
  end

  // request decode
  assign in_acc     = s_axis_tvalid && s_axis_tready;
  assign out_acc    = m_axis_tvalid && m_axis_tready;
  assign slot_index = s_axis_tdata[8:0];
  assign slot_value = s_axis_tdata[16:9];
  assign slot_base  = 10'(group_q) * 10'(CHANNELS);
  assign slot_off   = {1'b0, slot_index} - slot_base;
  assign slot_hit   = ({1'b0, slot_index} >= slot_base) && (slot_off < 10'(CHANNELS));
  assign slot_ch    = slot_off[CH_W-1:0];

  // lamp channels
  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    assign ctrl[c].tick    = in_acc && (s_axis_tuser == REQ_TICK);
    assign ctrl[c].mode_we = in_acc && (s_axis_tuser == REQ_SLOT) && slot_hit
                             && (slot_ch == CH_W'(c));
    assign ctrl[c].mode    = slot_value;

    tlms_chan u_chan (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl[c]),
      .lamp_o    (lamp_now[c]),
      .lamp_nx_o (lamp_nx[c])
    );
  end

  // result fields, missing channels read zero
  for (genvar j = 0; j < LAMPS_OUT; j++) begin : g_res
    if (j < CHANNELS) begin : g_live
      assign res_bits[j] = lamp_nx[j];
    end else begin : g_none
      assign res_bits[j] = 1'b0;
    end
  end

  // result queue
  always_comb begin
    unique case ({in_acc, out_acc})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (in_acc) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (out_acc) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fifo_q[wr_ptr_q] <= res_bits;
    end
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = {4'd0, fifo_q[rd_ptr_q]};

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue count out of range");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> m_axis_tvalid)
    else $error("accepted request left no result");

  a_slot_keeps_lamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (s_axis_tuser == REQ_SLOT)) |=> $stable(lamp_now))
    else $error("slot byte changed a lamp");

  a_idle_keeps_lamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(lamp_now))
    else $error("lamp changed without a request");

endmodule

### test/tlms_checker.sv
// Checker of the twinkle lamp mode sequencer: watches the request, result and APB channels,
// predicts the lamp word of every request and compares it with the block's output.
// Depends on tlms_pkg for the mode, request and register codes.
module tlms_checker
  import tlms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid,
  input  logic        req_ready,
  input  logic [23:0] req_data,     // [8:0] slot_index, [16:9] slot_value
  input  logic        req_kind,     // [0] req_type
  input  logic        lamp_valid,
  input  logic        lamp_ready,
  input  logic [7:0]  lamp_data,    // [0] lamp_zero .. [3] lamp_three
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatches,
  output int          lamps_due,
  output int          results_checked,
  output int          turn_ons,
  output int          saturated_ticks
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         NLAMP      = 4;
  localparam int         NPAT       = 3;
  localparam logic [9:0] MS_CEIL    = 10'd1023;
  localparam logic [2:0] GROUP_ADDR = REG_CHANNEL_GROUP;  // byte offset of the group register
  localparam int         PRINT_CAP  = 40;

  // predicted state of the block
  logic [3:0]       group_q;
  logic [7:0]       mode_q [NLAMP];
  logic [NLAMP-1:0] lamp_q;
  logic             lit_q  [NPAT][NLAMP];
  logic [2:0]       step_q [NPAT][NLAMP];
  logic [9:0]       ms_q   [NPAT][NLAMP];

  // lamp words still owed by the block, oldest first
  logic [NLAMP-1:0] lamp_words_due [$];

  // on duration in ms of a pattern step
  function automatic logic [9:0] on_ms(input int pat, input logic [2:0] st);
    logic [9:0] row [8];
    case (pat)
      0:       row = '{10'd18, 10'd23, 10'd16, 10'd15, 10'd14, 10'd12, 10'd21, 10'd12};
      1:       row = '{10'd12, 10'd17, 10'd11, 10'd15, 10'd14, 10'd12, 10'd17, 10'd12};
      default: row = '{10'd6, 10'd8, 10'd6, 10'd7, 10'd7, 10'd6, 10'd9, 10'd6};
    endcase
    return row[st];
  endfunction

  // off duration in ms of a pattern step
  function automatic logic [9:0] off_ms(input int pat, input logic [2:0] st);
    logic [9:0] row [8];
    case (pat)
      0:       row = '{10'd65, 10'd75, 10'd45, 10'd33, 10'd65, 10'd22, 10'd45, 10'd67};
      1:       row = '{10'd250, 10'd450, 10'd175, 10'd345, 10'd476, 10'd225, 10'd345, 10'd198};
      default: row = '{10'd500, 10'd900, 10'd350, 10'd690, 10'd925, 10'd500, 10'd690, 10'd400};
    endcase
    return row[st];
  endfunction

  task automatic clear_state();
    group_q = '0;
    lamp_q  = '0;
    for (int ch = 0; ch < NLAMP; ch++) begin
      mode_q[ch] = MODE_OFF;
      for (int p = 0; p < NPAT; p++) begin
        lit_q[p][ch]  = 1'b1;
        step_q[p][ch] = '0;
        ms_q[p][ch]   = '0;
      end
    end
    lamp_words_due.delete();
  endtask

  // one twinkle pattern on one channel: toggle when the current duration has run out
  task automatic run_twinkle(input int p, input int ch);
    if (lit_q[p][ch]) begin
      if (ms_q[p][ch] >= on_ms(p, step_q[p][ch])) begin
        lamp_q[ch]  = 1'b0;
        lit_q[p][ch] = 1'b0;
        ms_q[p][ch]  = '0;
      end
    end else if (ms_q[p][ch] >= off_ms(p, step_q[p][ch])) begin
      lamp_q[ch]   = 1'b1;
      lit_q[p][ch] = 1'b1;
      ms_q[p][ch]  = '0;
      step_q[p][ch] = (int'(step_q[p][ch]) + 1 >= STEPS) ? 3'd0 : step_q[p][ch] + 3'd1;
      turn_ons++;
    end
  endtask

  // millisecond tick: all timers count up first, then every lamp acts on its mode
  task automatic run_tick();
    bit any_sat;
    any_sat = 1'b0;
    for (int p = 0; p < NPAT; p++) begin
      for (int ch = 0; ch < NLAMP; ch++) begin
        if (ms_q[p][ch] < MS_CEIL) ms_q[p][ch]++;
        else any_sat = 1'b1;
      end
    end
    if (any_sat) saturated_ticks++;
    for (int ch = 0; ch < NLAMP; ch++) begin
      if (mode_q[ch] == MODE_OFF) begin
        lamp_q[ch] = 1'b0;
      end else if (mode_q[ch] == MODE_ON) begin
        lamp_q[ch] = 1'b1;
      end else if (mode_q[ch] <= MODE_PAT_C) begin
        run_twinkle(int'(mode_q[ch] - MODE_PAT_A), ch);
      end
    end
  endtask

  // slot byte: only the four slots of the selected group take a mode
  task automatic take_slot(input logic [8:0] slot, input logic [7:0] value);
    int base;
    base = int'(group_q) * NLAMP;
    if (int'(slot) >= base && int'(slot) - base < NLAMP) mode_q[int'(slot) - base] = value;
  endtask

  task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
    if (mismatches < PRINT_CAP)
      $display("checker: %s wrong in result %0d: want %0h, got %0h",
               what, results_checked, want, got);
    mismatches++;
  endtask

  task automatic check_lamps(input logic [7:0] got);
    string            lamp_name [NLAMP];
    logic [NLAMP-1:0] want;
    lamp_name = '{"lamp_zero", "lamp_one", "lamp_two", "lamp_three"};
    if (lamp_words_due.size() == 0) begin
      report("unrequested result", 8'h00, got);
    end else begin
      want = lamp_words_due.pop_front();
      for (int ch = 0; ch < NLAMP; ch++)
        if (got[ch] !== want[ch]) report(lamp_name[ch], {7'd0, want[ch]}, {7'd0, got[ch]});
      if (got[7:NLAMP] !== '0) report("padding", 8'h00, got);
    end
    results_checked++;
  endtask

  // results are popped before the request of the same edge is pushed
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
    end else begin
      if (lamp_valid && lamp_ready) check_lamps(lamp_data);
      if (req_valid && req_ready) begin
        if (req_kind == REQ_TICK) run_tick();
        else take_slot(req_data[8:0], req_data[16:9]);
        lamp_words_due.push_back(lamp_q);
      end
      if (psel && penable && pwrite && pready && paddr == GROUP_ADDR) group_q = pwdata[3:0];
    end
    lamps_due = lamp_words_due.size();
  end

endmodule

### test/testbench.sv
// Top of the twinkle lamp mode sequencer testbench: clock, reset, request and APB stimulus,
// result stalls and the verdict. Depends on tlms_pkg, the block and tlms_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tlms_pkg::*;

  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         RX_HOLD_LEN  = 300;
  localparam int         SETTLE_LEN   = 16;
  localparam int         STEADY_SPAN  = 40;
  localparam logic [2:0] GROUP_ADDR   = REG_CHANNEL_GROUP;
  localparam logic [7:0] MODE_PAT_B   = MODE_PAT_A + 8'd1;
  localparam logic [7:0] MODE_FIRST_HOLD = MODE_PAT_C + 8'd1;
  localparam logic [7:0] MODE_LAST_HOLD  = 8'd255;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [8:0] slot_index, [16:9] slot_value, rest zero
  logic        s_axis_tuser;   // [0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [0] lamp_zero, [1] lamp_one, [2] lamp_two, [3] lamp_three
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int lamps_due;
  int results_checked;
  int turn_ons;
  int saturated_ticks;

  int       cycles;
  int       ticks_sent;
  int       slots_sent;
  int       tx_count;
  bit       tx_steady;
  bit       rx_steady;
  bit       rx_hold_req;
  logic [3:0] group_sel;

  twinkle_lamp_mode_sequencer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  tlms_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid       (s_axis_tvalid),
    .req_ready       (s_axis_tready),
    .req_data        (s_axis_tdata),
    .req_kind        (s_axis_tuser),
    .lamp_valid      (m_axis_tvalid),
    .lamp_ready      (m_axis_tready),
    .lamp_data       (m_axis_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .mismatches      (mismatches),
    .lamps_due       (lamps_due),
    .results_checked (results_checked),
    .turn_ons        (turn_ons),
    .saturated_ticks (saturated_ticks)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("testbench: cycle limit of %0d reached", CYCLE_LIMIT);
    $display("testbench: done, errors");
    $finish;
  end

  // result side: random stalls per result, steady stretches, one long hold-off on request
  initial begin
    int gap;
    int rx_count;
    rx_count = 0;
    m_axis_tready <= 1'b0;
    forever begin
      if (rx_count % STEADY_SPAN == 0) rx_steady = ($urandom_range(0, 3) == 0);
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_LEN) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else begin
        gap = rx_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      rx_count++;
    end
  end

  // one request, after a random gap unless in a steady stretch
  task automatic put_request(input logic kind, input logic [8:0] slot, input logic [7:0] value);
    int gap;
    if (tx_count % STEADY_SPAN == 0) tx_steady = ($urandom_range(0, 3) == 0);
    gap = tx_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {7'd0, value, slot};
    do @(posedge clk_i); while (!s_axis_tready);
    tx_count++;
    if (kind == REQ_TICK) ticks_sent++;
    else slots_sent++;
  endtask

  // tick with random contents in the ignored fields
  task automatic tick();
    put_request(REQ_TICK, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
  endtask

  task automatic slot_byte(input int slot, input logic [7:0] value);
    put_request(REQ_SLOT, 9'(slot), value);
  endtask

  // stop offering and wait until every lamp word has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (lamps_due != 0) @(posedge clk_i);
    repeat (SETTLE_LEN) @(posedge clk_i);
  endtask

  // APB write of the group register: setup cycle, then access cycle
  task automatic write_group(input logic [3:0] grp);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= GROUP_ADDR;
    pwdata  <= {28'd0, grp};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pwdata  <= '0;
    group_sel = grp;
  endtask

  // mostly ticks and mode bytes for the selected group, some noise anywhere
  task automatic random_request(input int tick_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < tick_pct) begin
      tick();
    end else if (roll < tick_pct + (100 - tick_pct) * 3 / 4) begin
      slot_byte(int'(group_sel) * 4 + $urandom_range(0, 3),
                ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 4))
                                            : 8'($urandom_range(0, 255)));
    end else begin
      slot_byte($urandom_range(0, 511), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_phase(input logic [3:0] grp, input int count, input int tick_pct,
                              input bit hold_rx, input bit pause_mid);
    drain();
    write_group(grp);
    for (int i = 0; i < count; i++) begin
      if (hold_rx && i == count / 2) rx_hold_req = 1'b1;
      if (pause_mid && i == count / 2) drain();
      random_request(tick_pct);
    end
  endtask

  // stimulus and verdict
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_TICK;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rx_hold_req   = 1'b0;
    tx_count      = 0;
    ticks_sent    = 0;
    slots_sent    = 0;
    group_sel     = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: forced modes, all patterns, ignored slots, holding modes
    write_group(4'd0);
    tick();
    slot_byte(0, MODE_ON);
    tick();
    slot_byte(1, MODE_PAT_A);
    slot_byte(2, MODE_PAT_B);
    slot_byte(3, MODE_PAT_C);
    tick();
    slot_byte(4, MODE_ON);
    slot_byte(511, MODE_LAST_HOLD);
    slot_byte(0, MODE_FIRST_HOLD);
    tick();
    slot_byte(0, MODE_LAST_HOLD);
    tick();
    slot_byte(0, MODE_OFF);
    repeat (8) tick();

    // highest group: its four slots and the neighbor below
    drain();
    write_group(4'd15);
    slot_byte(59, MODE_ON);
    slot_byte(60, MODE_PAT_C);
    slot_byte(61, MODE_PAT_B);
    slot_byte(62, MODE_PAT_A);
    slot_byte(63, MODE_ON);
    repeat (6) tick();

    // random phases, the last one tick-heavy so the patterns run through many steps
    random_phase(4'd15, 120, 70, 1'b0, 1'b0);
    random_phase(4'($urandom_range(1, 14)), 120, 70, 1'b1, 1'b0);
    random_phase(4'd0, 120, 70, 1'b0, 1'b1);
    random_phase(4'($urandom_range(0, 15)), 100, 80, 1'b0, 1'b0);
    random_phase(4'($urandom_range(0, 15)), 160, 97, 1'b0, 1'b0);
    drain();

    $display("testbench: %0d requests sent (%0d ticks, %0d slot bytes), %0d lamp words checked",
             tx_count, ticks_sent, slots_sent, results_checked);
    $display("testbench: %0d twinkle turn-ons, %0d ticks with a saturated timer, groups 0 and 15",
             turn_ons, saturated_ticks);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
